>>> rtl/core/emc_pkg.sv
package emc_pkg;

  localparam int NUM_SETTINGS = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX   = 3'd3;

  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [7:0]  TEMP_MIN_RST   = 8'd30;
  localparam logic [7:0]  TEMP_MAX_RST   = 8'd250;
  localparam logic [7:0]  SETPOINT_RST   = 8'd100;
  localparam logic [3:0]  INTENSITY_RST  = 4'd5;
  localparam logic [3:0]  INTENSITY_MIN  = 4'd1;
  localparam logic [3:0]  INTENSITY_MAX  = 4'd10;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_SETTINGS = 2'd1;
  localparam logic [1:0] MODE_EDIT     = 2'd2;

  localparam logic [3:0] SEL_TEMP      = 4'd0;
  localparam logic [3:0] SEL_INTENSITY = 4'd1;
  localparam logic [3:0] SEL_LAST      = 4'(NUM_SETTINGS - 1);

  localparam logic [2:0] SYS_IDLE     = 3'd0;
  localparam logic [2:0] SYS_PAN_DET  = 3'd1;
  localparam logic [2:0] SYS_PREHEAT  = 3'd2;
  localparam logic [2:0] SYS_HEATING  = 3'd3;
  localparam logic [2:0] SYS_COOLDOWN = 3'd4;
  localparam logic [2:0] SYS_FAULT    = 3'd5;

  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_OCP      = 3'd1;
  localparam logic [2:0] FLT_OVERTEMP = 3'd2;
  localparam logic [2:0] FLT_FAN      = 3'd3;
  localparam logic [2:0] FLT_WDT      = 3'd4;

  localparam logic [2:0] PAT_OFF        = 3'd0;
  localparam logic [2:0] PAT_ON         = 3'd1;
  localparam logic [2:0] PAT_BLINK_SLOW = 3'd2;
  localparam logic [2:0] PAT_BLINK_FAST = 3'd3;
  localparam logic [2:0] PAT_DOUBLE     = 3'd4;

  localparam logic TGT_PAN_DETECT = 1'b0;
  localparam logic TGT_COOLDOWN   = 1'b1;

  typedef struct packed {
    logic signed [15:0] encoder_count;
    logic               button_level;
    logic [31:0]        now_ms;
    logic [2:0]         system_state;
    logic [2:0]         fault_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] ui_mode;
    logic [3:0] selected_item;
    logic [7:0] temp_setpoint;
    logic       temp_write;
    logic [3:0] intensity_level;
    logic       intensity_write;
    logic       force_request;
    logic       force_target;
    logic [2:0] master_pattern;
    logic       ocp_led_on;
    logic       thermal_led_on;
    logic       wdt_led_on;
  } out_item_t;

  typedef struct packed {
    logic [3:0] sel;
    logic [7:0] setpoint;
    logic [3:0] intensity;
    logic       temp_write;
    logic       int_write;
  } rot_res_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        held;
    logic [31:0] press_start;
    logic        force_req;
    logic        force_tgt;
  } btn_res_t;

  typedef struct packed {
    logic [2:0] master;
    logic       ocp;
    logic       thermal;
    logic       wdt;
  } led_res_t;

endpackage

>>> rtl/core/emc_if.sv
interface emc_in_if;
  logic               valid;
  logic               ready;
  emc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface emc_out_if;
  logic               valid;
  logic               ready;
  emc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/emc_rot.sv
module emc_rot (
  input  logic signed [15:0] count,
  input  logic [15:0]        last_count,
  input  logic [1:0]         mode,
  input  logic [3:0]         sel,
  input  logic [7:0]         setpoint,
  input  logic [3:0]         intensity,
  input  logic [7:0]         temp_min,
  input  logic [7:0]         temp_max,
  output emc_pkg::rot_res_t  res
);
  import emc_pkg::*;

  logic [15:0]        raw;
  logic signed [15:0] delta;
  logic signed [21:0] d22;
  logic signed [21:0] x5;
  logic signed [21:0] x50;
  logic signed [21:0] eff;
  logic signed [22:0] tsum;
  logic signed [22:0] tlo;
  logic signed [22:0] thi;
  logic signed [22:0] tclamp;
  logic signed [17:0] isum;
  logic [3:0]         iclamp;
  logic [3:0]         s;
  logic [3:0]         s_up;
  logic [3:0]         s_dn;

  assign raw   = 16'(count) - last_count;
  assign delta = raw;
  assign d22   = {{6{delta[15]}}, delta};
  assign x5    = (d22 <<< 2) + d22;
  assign x50   = (x5 <<< 3) + (x5 <<< 1);

  always_comb begin
    if (delta > 16'sd10 || delta < -16'sd10) begin
      eff = x50;
    end else if (delta > 16'sd5 || delta < -16'sd5) begin
      eff = x5;
    end else begin
      eff = d22;
    end
  end

  // raise to min first, then lower to max
  assign tsum = {eff[21], eff} + {15'd0, setpoint};
  assign tlo  = {15'd0, temp_min};
  assign thi  = {15'd0, temp_max};

  always_comb begin
    tclamp = tsum;
    if (tclamp < tlo) tclamp = tlo;
    if (tclamp > thi) tclamp = thi;
  end

  assign isum = {{2{delta[15]}}, delta} + {14'd0, intensity};

  always_comb begin
    if (isum < $signed({14'd0, INTENSITY_MIN})) begin
      iclamp = INTENSITY_MIN;
    end else if (isum > $signed({14'd0, INTENSITY_MAX})) begin
      iclamp = INTENSITY_MAX;
    end else begin
      iclamp = isum[3:0];
    end
  end

  assign s    = 4'(sel % NUM_SETTINGS);
  assign s_up = (s == SEL_LAST) ? SEL_TEMP : s + 4'd1;
  assign s_dn = (s == SEL_TEMP) ? SEL_LAST : s - 4'd1;

  always_comb begin
    res.sel        = sel;
    res.setpoint   = setpoint;
    res.intensity  = intensity;
    res.temp_write = 1'b0;
    res.int_write  = 1'b0;
    if (delta != 16'sd0) begin
      case (mode)
        MODE_NORMAL: begin
          res.setpoint   = tclamp[7:0];
          res.temp_write = 1'b1;
        end
        MODE_SETTINGS: begin
          res.sel = (delta > 16'sd0) ? s_up : s_dn;
        end
        MODE_EDIT: begin
          if (sel == SEL_TEMP) begin
            res.setpoint   = tclamp[7:0];
            res.temp_write = 1'b1;
          end else if (sel == SEL_INTENSITY) begin
            res.intensity = iclamp;
            res.int_write = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/emc_btn.sv
module emc_btn (
  input  logic              pressed,
  input  logic [31:0]       now_ms,
  input  logic [2:0]        system_state,
  input  logic [1:0]        mode,
  input  logic              held,
  input  logic [31:0]       press_start,
  input  logic [15:0]       long_press_lim,
  input  logic [15:0]       debounce_lim,
  output emc_pkg::btn_res_t res
);
  import emc_pkg::*;

  logic [31:0] dur;
  logic        counted;
  logic        is_long;

  assign dur     = now_ms - press_start;
  assign counted = dur > {16'd0, debounce_lim};
  assign is_long = dur >= {16'd0, long_press_lim};

  always_comb begin
    res.mode        = mode;
    res.held        = held;
    res.press_start = press_start;
    res.force_req   = 1'b0;
    res.force_tgt   = TGT_PAN_DETECT;
    if (pressed && !held) begin
      res.press_start = now_ms;
      res.held        = 1'b1;
    end else if (!pressed && held) begin
      res.held = 1'b0;
      if (counted) begin
        case (mode)
          MODE_NORMAL: begin
            if (is_long) begin
              res.mode = MODE_SETTINGS;
            end else begin
              res.force_req = 1'b1;
              res.force_tgt = (system_state == SYS_IDLE) ? TGT_PAN_DETECT : TGT_COOLDOWN;
            end
          end
          MODE_SETTINGS: res.mode = is_long ? MODE_NORMAL : MODE_EDIT;
          MODE_EDIT:     res.mode = is_long ? MODE_NORMAL : MODE_SETTINGS;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/core/emc_led.sv
module emc_led (
  input  logic [2:0]        system_state,
  input  logic [2:0]        fault_code,
  output emc_pkg::led_res_t res
);
  import emc_pkg::*;

  always_comb begin
    res.ocp     = 1'b0;
    res.thermal = 1'b0;
    res.wdt     = 1'b0;
    if (system_state == SYS_FAULT || fault_code != FLT_NONE) begin
      res.master = PAT_BLINK_FAST;
      case (fault_code)
        FLT_OCP:      res.ocp     = 1'b1;
        FLT_OVERTEMP: res.thermal = 1'b1;
        FLT_FAN:      res.wdt     = 1'b1;
        FLT_WDT:      res.wdt     = 1'b1;
        default: begin
        end
      endcase
    end else begin
      case (system_state)
        SYS_PAN_DET:  res.master = PAT_BLINK_SLOW;
        SYS_PREHEAT:  res.master = PAT_BLINK_FAST;
        SYS_HEATING:  res.master = PAT_ON;
        SYS_COOLDOWN: res.master = PAT_DOUBLE;
        default:      res.master = PAT_OFF;
      endcase
    end
  end

endmodule

>>> rtl/core/encoder_menu_controller.sv
// Encoder and push-button menu controller for a heater.
// in_if carries one poll tick per item: encoder count, button level, ms
// timestamp, system state and fault code. out_if returns one result item
// per tick: menu mode, selection, setpoint, intensity, write strobes,
// start/stop request and LED patterns.
// cfg_we/cfg_idx/cfg_wdata write the long-press time, debounce time and
// setpoint limits; write only while no item is in flight.
// Path: an accepted tick is held in the input register; its result is then
// registered in the result register and shown on out_if.
// Throughput: one item per cycle when out_if.ready is high; the menu state
// is read and updated between the registers, so consecutive ticks chain.
// Reset (rst_n low, synchronous) empties both registers and restores the
// configuration and menu state to their defaults.
// When out_if.ready is low the result register holds its item, the input
// register fills, and in_if.ready drops until the result is taken.
module encoder_menu_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  emc_in_if.sink                           in_if,
  emc_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [emc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [emc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import emc_pkg::*;

  logic [15:0] long_press_r;
  logic [15:0] debounce_r;
  logic [7:0]  temp_min_r;
  logic [7:0]  temp_max_r;

  logic [1:0]  mode_r;
  logic [3:0]  sel_r;
  logic [15:0] last_count_r;
  logic [31:0] press_start_r;
  logic        held_r;
  logic [7:0]  setpoint_r;
  logic [3:0]  intensity_r;

  logic        s1_valid_r;
  in_item_t    s1_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        in_acc;
  logic        advance;
  rot_res_t    rot;
  btn_res_t    btn;
  led_res_t    led;
  out_item_t   res_nxt;

  assign advance      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || advance;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  emc_rot u_rot (
    .count      (s1_data_r.encoder_count),
    .last_count (last_count_r),
    .mode       (mode_r),
    .sel        (sel_r),
    .setpoint   (setpoint_r),
    .intensity  (intensity_r),
    .temp_min   (temp_min_r),
    .temp_max   (temp_max_r),
    .res        (rot)
  );

  emc_btn u_btn (
    .pressed        (s1_data_r.button_level),
    .now_ms         (s1_data_r.now_ms),
    .system_state   (s1_data_r.system_state),
    .mode           (mode_r),
    .held           (held_r),
    .press_start    (press_start_r),
    .long_press_lim (long_press_r),
    .debounce_lim   (debounce_r),
    .res            (btn)
  );

  emc_led u_led (
    .system_state (s1_data_r.system_state),
    .fault_code   (s1_data_r.fault_code),
    .res          (led)
  );

  always_comb begin
    res_nxt.ui_mode         = btn.mode;
    res_nxt.selected_item   = rot.sel;
    res_nxt.temp_setpoint   = rot.setpoint;
    res_nxt.temp_write      = rot.temp_write;
    res_nxt.intensity_level = rot.intensity;
    res_nxt.intensity_write = rot.int_write;
    res_nxt.force_request   = btn.force_req;
    res_nxt.force_target    = btn.force_tgt;
    res_nxt.master_pattern  = led.master;
    res_nxt.ocp_led_on      = led.ocp;
    res_nxt.thermal_led_on  = led.thermal;
    res_nxt.wdt_led_on      = led.wdt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      debounce_r   <= DEBOUNCE_RST;
      temp_min_r   <= TEMP_MIN_RST;
      temp_max_r   <= TEMP_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[15:0];
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[15:0];
        CFG_TEMP_MIN:   temp_min_r   <= cfg_wdata[7:0];
        CFG_TEMP_MAX:   temp_max_r   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_NORMAL;
      sel_r         <= SEL_TEMP;
      last_count_r  <= 16'd0;
      press_start_r <= 32'd0;
      held_r        <= 1'b0;
      setpoint_r    <= SETPOINT_RST;
      intensity_r   <= INTENSITY_RST;
    end else if (advance) begin
      mode_r        <= btn.mode;
      sel_r         <= rot.sel;
      last_count_r  <= 16'(s1_data_r.encoder_count);
      press_start_r <= btn.press_start;
      held_r        <= btn.held;
      setpoint_r    <= rot.setpoint;
      intensity_r   <= rot.intensity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_if.data;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  a_intensity_range: assert property (@(posedge clk) disable iff (!rst_n)
    intensity_r >= INTENSITY_MIN && intensity_r <= INTENSITY_MAX)
    else $error("intensity out of range");

  a_force_in_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.force_request |-> out_data_r.ui_mode == MODE_NORMAL)
    else $error("start/stop request outside normal mode");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.temp_write && out_data_r.intensity_write))
    else $error("setpoint and intensity written by one item");

  a_stage_drain: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_acc |=> !s1_valid_r)
    else $error("input register kept an item it already passed on");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed item lost before result register");

endmodule
